// ===== hdl/bta_pkg.sv =====
// shared codes and tag constants for the boundary tag first-fit allocator
// no dependencies
`default_nettype none
package bta_pkg;
    typedef logic [1:0] code_t;

    localparam code_t ACT_INIT  = 2'd0;
    localparam code_t ACT_ALLOC = 2'd1;
    localparam code_t ACT_FREE  = 2'd2;

    localparam code_t ST_OK        = 2'd0;
    localparam code_t ST_NO_SPACE  = 2'd1;
    localparam code_t ST_NOT_READY = 2'd2;

    localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
    localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
    localparam logic [31:0] MIN_BLOCK = 32'd16;
    localparam logic [31:0] PRO_TAG   = 32'h0000_0009;
endpackage
`default_nettype wire

// ===== hdl/boundary_tag_first_fit_allocator.sv =====
// heap allocator engine: tag memory, first-fit walk, grow, place, free and merge
// depends on bta_pkg
`default_nettype none
// One item in, one result item out. Boundary tags sit in a word memory with one
// read and one write port and a registered read, and each state makes at most
// one tag access. Init writes the prologue and epilogue tags, then grows the
// heap. Free is refused at once, stops when the header there is not an
// allocated block, else marks the block free and merges it with any free
// neighbour. Allocate is refused, or walks the blocks first-fit, then places
// the block, splitting it when the rest is large enough. When no block fits,
// the heap grows and the new space merges with a free last block; a failed
// growth answers with no space. A new item is taken while the last result still
// waits, and the block then holds in its final state until the receiver takes
// that result.
module boundary_tag_first_fit_allocator #(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[1:0], request_size[17:2], block_address[33:18], zeros above
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], payload_address[17:2], zeros above
    output logic [23:0]      m_axis_tdata
);
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int IDXW       = $clog2(HEAP_WORDS);
    localparam int BRKW       = $clog2(HEAP_BYTES + 1);
    localparam int STEP_LIM   = HEAP_BYTES / 8 + 2;
    localparam int STW        = $clog2(STEP_LIM + 1);
    localparam logic [31:0] HEAP_B  = 32'(HEAP_BYTES);
    localparam logic [31:0] CHUNK_B = 32'(CHUNK_BYTES);

    localparam logic [4:0] S_IDLE = 5'd0,  S_INIT0 = 5'd1,  S_INIT1 = 5'd2,
                           S_INIT2 = 5'd3, S_INIT3 = 5'd4,  S_GROW = 5'd5,
                           S_GW0 = 5'd6,   S_GW1 = 5'd7,    S_GW2 = 5'd8,
                           S_M0 = 5'd9,    S_M1 = 5'd10,    S_M2 = 5'd11,
                           S_M3 = 5'd12,   S_MW0 = 5'd13,   S_MW1 = 5'd14,
                           S_F0 = 5'd15,   S_F1 = 5'd16,    S_P0 = 5'd17,
                           S_P1 = 5'd18,   S_PW0 = 5'd19,   S_PW1 = 5'd20,
                           S_PW2 = 5'd21,  S_PW3 = 5'd22,   S_R0 = 5'd23,
                           S_R1 = 5'd24,   S_RW0 = 5'd25,   S_RW1 = 5'd26,
                           S_DONE = 5'd27, S_MDONE = 5'd28;

    logic [4:0]        state_reg, state_next;
    bta_pkg::code_t    act_reg, act_next;
    logic [31:0]       need_reg, need_next;
    logic [31:0]       bp_reg, bp_next;
    logic [31:0]       size_reg, size_next;
    logic [31:0]       prev_reg, prev_next;
    logic [31:0]       greq_reg, greq_next;
    logic [31:0]       have_reg, have_next;
    logic              split_reg, split_next;
    logic [STW-1:0]    steps_reg, steps_next;
    logic [BRKW-1:0]   brk_reg, brk_next;
    logic              ready_reg, ready_next;
    bta_pkg::code_t    res_st_reg, res_st_next;
    logic [15:0]       res_pl_reg, res_pl_next;
    logic              out_valid_reg;
    logic [17:0]       out_data_reg;

    // memory port signals
    logic              rd_en, wr_en;
    logic [31:0]       rd_off, wr_off, wr_val;
    logic [31:0]       mem [HEAP_WORDS];
    logic [31:0]       rd_q;
    logic              rd_oor_reg;
    logic [31:0]       tag;

    // input fields
    bta_pkg::code_t    in_action;
    logic [15:0]       in_req, in_addr;
    logic [31:0]       brk32, gw, gbytes, psz, nsz, tsz;
    logic              prev_used, next_used;

    assign in_action = s_axis_tdata[1:0];
    assign in_req    = s_axis_tdata[17:2];
    assign in_addr   = s_axis_tdata[33:18];
    assign brk32     = 32'(brk_reg);
    assign tag       = rd_oor_reg ? 32'd0 : rd_q;
    assign tsz       = tag & bta_pkg::SIZE_MASK;

    // growth size: whole words, then an even number of words
    assign gw     = greq_reg >> 2;
    assign gbytes = (gw + {31'd0, gw[0]}) << 2;

    // merge sums
    assign prev_used = (prev_reg & bta_pkg::ALLOC_BIT) != 32'd0;
    assign next_used = (tag & bta_pkg::ALLOC_BIT) != 32'd0;
    assign psz       = prev_reg & bta_pkg::SIZE_MASK;
    assign nsz       = size_reg + (next_used ? 32'd0 : tsz) + (prev_used ? 32'd0 : psz);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    // tag memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_off < HEAP_B)
        begin
            mem[wr_off[IDXW+1:2]] <= wr_val;
        end
        if (rd_en)
        begin
            rd_q       <= mem[rd_off[IDXW+1:2]];
            rd_oor_reg <= !(rd_off < HEAP_B);
        end
    end

    // memory access per state
    always_comb
    begin
        rd_en  = 1'b0;
        rd_off = 32'd0;
        wr_en  = 1'b0;
        wr_off = 32'd0;
        wr_val = 32'd0;
        case (state_reg)
            S_INIT0: begin wr_en = 1'b1; wr_off = 32'd0;  wr_val = 32'd0; end
            S_INIT1: begin wr_en = 1'b1; wr_off = 32'd4;  wr_val = bta_pkg::PRO_TAG; end
            S_INIT2: begin wr_en = 1'b1; wr_off = 32'd8;  wr_val = bta_pkg::PRO_TAG; end
            S_INIT3: begin wr_en = 1'b1; wr_off = 32'd12; wr_val = bta_pkg::ALLOC_BIT; end
            S_GW0:   begin wr_en = 1'b1; wr_off = bp_reg - 32'd4; wr_val = size_reg; end
            S_GW1:
            begin
                wr_en = 1'b1; wr_off = bp_reg + size_reg - 32'd8; wr_val = size_reg;
            end
            S_GW2:
            begin
                wr_en = 1'b1; wr_off = bp_reg + size_reg - 32'd4;
                wr_val = bta_pkg::ALLOC_BIT;
            end
            S_M0:    begin rd_en = 1'b1; rd_off = bp_reg - 32'd4; end
            S_M1:    begin rd_en = 1'b1; rd_off = bp_reg - 32'd8; end
            S_M2:    begin rd_en = 1'b1; rd_off = bp_reg + size_reg - 32'd4; end
            S_MW0, S_RW0:
            begin
                wr_en = 1'b1; wr_off = bp_reg - 32'd4; wr_val = size_reg;
            end
            S_MW1, S_RW1:
            begin
                wr_en = 1'b1; wr_off = bp_reg + size_reg - 32'd8; wr_val = size_reg;
            end
            S_F0:    begin rd_en = (bp_reg < brk32) && (32'(steps_reg) < 32'(STEP_LIM));
                           rd_off = bp_reg - 32'd4; end
            S_P0, S_R0: begin rd_en = 1'b1; rd_off = bp_reg - 32'd4; end
            S_PW0:
            begin
                wr_en = 1'b1; wr_off = bp_reg - 32'd4;
                wr_val = (split_reg ? need_reg : have_reg) | bta_pkg::ALLOC_BIT;
            end
            S_PW1:
            begin
                wr_en = 1'b1;
                wr_off = bp_reg + (split_reg ? need_reg : have_reg) - 32'd8;
                wr_val = (split_reg ? need_reg : have_reg) | bta_pkg::ALLOC_BIT;
            end
            S_PW2:
            begin
                wr_en = 1'b1; wr_off = bp_reg + need_reg - 32'd4;
                wr_val = have_reg - need_reg;
            end
            S_PW3:
            begin
                wr_en = 1'b1; wr_off = bp_reg + have_reg - 32'd8;
                wr_val = have_reg - need_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        need_next   = need_reg;
        bp_next     = bp_reg;
        size_next   = size_reg;
        prev_next   = prev_reg;
        greq_next   = greq_reg;
        have_next   = have_reg;
        split_next  = split_reg;
        steps_next  = steps_reg;
        brk_next    = brk_reg;
        ready_next  = ready_reg;
        res_st_next = res_st_reg;
        res_pl_next = res_pl_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next    = in_action;
                    res_st_next = bta_pkg::ST_OK;
                    res_pl_next = 16'd0;
                    state_next  = S_DONE;
                    case (in_action)
                        bta_pkg::ACT_INIT:
                        begin
                            brk_next   = BRKW'(16);
                            greq_next  = CHUNK_B;
                            state_next = S_INIT0;
                        end
                        bta_pkg::ACT_ALLOC:
                        begin
                            if (!ready_reg)
                                res_st_next = bta_pkg::ST_NOT_READY;
                            else if (in_req == 16'd0)
                                res_st_next = bta_pkg::ST_NO_SPACE;
                            else
                            begin
                                need_next  = (in_req <= 16'd8) ? bta_pkg::MIN_BLOCK :
                                    ((32'(in_req) + 32'd15) & bta_pkg::SIZE_MASK);
                                bp_next    = 32'd8;
                                steps_next = '0;
                                state_next = S_F0;
                            end
                        end
                        bta_pkg::ACT_FREE:
                        begin
                            if (!ready_reg)
                                res_st_next = bta_pkg::ST_NOT_READY;
                            else if (in_addr >= 16'd16 && in_addr[2:0] == 3'd0 &&
                                     32'(in_addr) < brk32)
                            begin
                                bp_next    = 32'(in_addr);
                                state_next = S_R0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT0: state_next = S_INIT1;
            S_INIT1: state_next = S_INIT2;
            S_INIT2: state_next = S_INIT3;
            S_INIT3: state_next = S_GROW;
            S_GROW:
            begin
                if (gbytes == 32'd0 || gbytes > HEAP_B - brk32)
                begin
                    res_st_next = bta_pkg::ST_NO_SPACE;
                    if (act_reg == bta_pkg::ACT_INIT)
                        ready_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    bp_next    = brk32;
                    size_next  = gbytes;
                    brk_next   = BRKW'(brk32 + gbytes);
                    state_next = S_GW0;
                end
            end
            S_GW0: state_next = S_GW1;
            S_GW1: state_next = S_GW2;
            S_GW2: state_next = S_M0;
            S_M0:  state_next = S_M1;
            S_M1:
            begin
                size_next  = tsz;
                state_next = S_M2;
            end
            S_M2:
            begin
                prev_next  = tag;
                state_next = S_M3;
            end
            S_M3:
            begin
                size_next = nsz;
                if (!prev_used)
                    bp_next = bp_reg - psz;
                state_next = (!prev_used || !next_used) ? S_MW0 : S_MDONE;
            end
            S_MW0: state_next = S_MW1;
            S_MW1: state_next = S_MDONE;
            S_MDONE:
            begin
                case (act_reg)
                    bta_pkg::ACT_INIT:
                    begin
                        ready_next = 1'b1;
                        state_next = S_DONE;
                    end
                    bta_pkg::ACT_ALLOC: state_next = S_P0;
                    default: state_next = S_DONE;
                endcase
            end
            S_F0:
            begin
                if (bp_reg < brk32 && 32'(steps_reg) < 32'(STEP_LIM))
                    state_next = S_F1;
                else
                begin
                    greq_next  = (need_reg > CHUNK_B) ? need_reg : CHUNK_B;
                    state_next = S_GROW;
                end
            end
            S_F1:
            begin
                if (tsz == 32'd0)
                begin
                    greq_next  = (need_reg > CHUNK_B) ? need_reg : CHUNK_B;
                    state_next = S_GROW;
                end
                else if ((tag & bta_pkg::ALLOC_BIT) == 32'd0 && tsz >= need_reg)
                    state_next = S_P0;
                else
                begin
                    bp_next    = bp_reg + tsz;
                    steps_next = steps_reg + STW'(1);
                    state_next = S_F0;
                end
            end
            S_P0: state_next = S_P1;
            S_P1:
            begin
                have_next  = tsz;
                split_next = (tsz >= need_reg) && (tsz - need_reg >= bta_pkg::MIN_BLOCK);
                state_next = S_PW0;
            end
            S_PW0: state_next = S_PW1;
            S_PW1:
            begin
                res_pl_next = bp_reg[15:0];
                state_next  = split_reg ? S_PW2 : S_DONE;
            end
            S_PW2: state_next = S_PW3;
            S_PW3: state_next = S_DONE;
            S_R0:  state_next = S_R1;
            S_R1:
            begin
                if (tsz != 32'd0 && (tag & bta_pkg::ALLOC_BIT) != 32'd0)
                begin
                    size_next  = tsz;
                    state_next = S_RW0;
                end
                else
                    state_next = S_DONE;
            end
            S_RW0: state_next = S_RW1;
            S_RW1: state_next = S_M0;
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            brk_reg       <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            brk_reg   <= brk_next;
            ready_reg <= ready_next;
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        need_reg   <= need_next;
        bp_reg     <= bp_next;
        size_reg   <= size_next;
        prev_reg   <= prev_next;
        greq_reg   <= greq_next;
        have_reg   <= have_next;
        split_reg  <= split_next;
        steps_reg  <= steps_next;
        res_st_reg <= res_st_next;
        res_pl_reg <= res_pl_next;
        if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {res_pl_reg, res_st_reg};
    end

    // checks
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("read and write in one cycle");
    a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(brk_reg) <= HEAP_B)
        else $error("break beyond heap");
    a_ready_brk: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> 32'(brk_reg) >= 32'd16)
        else $error("heap ready with no frame");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg != S_IDLE)
        else $error("item accepted without work");
endmodule
`default_nettype wire

// ===== sim/tb_boundary_tag_first_fit_allocator.sv =====
// testbench for the boundary tag first-fit heap allocator: directed table then random traffic
// depends on bta_pkg and boundary_tag_first_fit_allocator
`timescale 1ns / 1ps
module tb_boundary_tag_first_fit_allocator;
    localparam int             HEAP_BYTES   = 65536;
    localparam int             CHUNK_BYTES  = 4096;
    localparam int             HEAP_WORDS   = HEAP_BYTES / 4;
    localparam bta_pkg::code_t ACT_NONE     = 2'd3;
    localparam int             RANDOM_ITEMS = 525;

    typedef struct packed {
        bta_pkg::code_t act;
        logic [15:0]    req;
        logic [15:0]    addr;
        logic           typed;
        bta_pkg::code_t st;
        logic [15:0]    pay;
    } row_t;

    typedef struct packed {
        bta_pkg::code_t st;
        logic [15:0]    pay;
    } reply_t;

    typedef enum logic [1:0] {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // action[1:0], request_size[17:2], block_address[33:18], zeros above
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status[1:0], payload_address[17:2], zeros above
    logic [23:0] m_axis_tdata;

    // predictor state
    logic [31:0] tag_mem [HEAP_WORDS];
    logic [31:0] heap_top;
    logic        heap_built;
    logic [15:0] live_blocks[$];
    reply_t      pending_replies[$];

    int    fail_count;
    int    items_sent;
    pace_t pace;
    logic  hold_done;

    boundary_tag_first_fit_allocator #(
        .HEAP_BYTES (HEAP_BYTES),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // directed items: reset, extremes, every action and the misplaced frees
    row_t dir_rows [] = '{
        '{bta_pkg::ACT_ALLOC, 16'd8,     16'd0,    1'b1, bta_pkg::ST_NOT_READY, 16'd0},
        '{bta_pkg::ACT_FREE,  16'd0,     16'd16,   1'b1, bta_pkg::ST_NOT_READY, 16'd0},
        '{bta_pkg::ACT_INIT,  16'd0,     16'd0,    1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_ALLOC, 16'd0,     16'd0,    1'b1, bta_pkg::ST_NO_SPACE,  16'd0},
        '{bta_pkg::ACT_ALLOC, 16'd1,     16'd0,    1'b1, bta_pkg::ST_OK,        16'd16},
        '{bta_pkg::ACT_ALLOC, 16'd8,     16'd0,    1'b1, bta_pkg::ST_OK,        16'd32},
        '{bta_pkg::ACT_ALLOC, 16'd9,     16'd0,    1'b1, bta_pkg::ST_OK,        16'd48},
        '{bta_pkg::ACT_ALLOC, 16'hFFFF,  16'hFFFF, 1'b1, bta_pkg::ST_NO_SPACE,  16'd0},
        '{ACT_NONE,           16'hFFFF,  16'hFFFF, 1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_FREE,  16'd0,     16'd12,   1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_FREE,  16'd0,     16'd17,   1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_FREE,  16'hFFFF,  16'hFFF8, 1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_FREE,  16'd0,     16'd32,   1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_ALLOC, 16'd16,    16'd0,    1'b0, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_ALLOC, 16'd4096,  16'd0,    1'b0, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_ALLOC, 16'd30000, 16'd0,    1'b0, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_ALLOC, 16'd30000, 16'd0,    1'b0, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_FREE,  16'd0,     16'd16,   1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_FREE,  16'd0,     16'd48,   1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_INIT,  16'hFFFF,  16'hFFFF, 1'b1, bta_pkg::ST_OK,        16'd0},
        '{bta_pkg::ACT_ALLOC, 16'd1,     16'd0,    1'b1, bta_pkg::ST_OK,        16'd16},
        '{bta_pkg::ACT_ALLOC, 16'd65528, 16'd0,    1'b1, bta_pkg::ST_NO_SPACE,  16'd0}
    };

    function automatic logic [31:0] tag_rd(logic [31:0] off);
        if ((off >> 2) >= HEAP_WORDS)
            return 32'd0;
        return tag_mem[off >> 2];
    endfunction

    function automatic void tag_wr(logic [31:0] off, logic [31:0] val);
        if ((off >> 2) < HEAP_WORDS)
            tag_mem[off >> 2] = val;
    endfunction

    function automatic void mark_block(logic [31:0] bp, logic [31:0] sz, logic [31:0] used);
        tag_wr(bp - 4, sz | used);
        tag_wr(bp + sz - 8, sz | used);
    endfunction

    function automatic logic [31:0] merge_neighbours(logic [31:0] bp);
        logic [31:0] sz;
        logic [31:0] prev_tag;
        logic [31:0] next_tag;
        sz       = tag_rd(bp - 4) & bta_pkg::SIZE_MASK;
        prev_tag = tag_rd(bp - 8);
        next_tag = tag_rd(bp + sz - 4);
        if (next_tag[0] == 1'b0)
            sz += next_tag & bta_pkg::SIZE_MASK;
        if (prev_tag[0] == 1'b0)
        begin
            bp -= prev_tag & bta_pkg::SIZE_MASK;
            sz += prev_tag & bta_pkg::SIZE_MASK;
        end
        if (prev_tag[0] == 1'b0 || next_tag[0] == 1'b0)
            mark_block(bp, sz, 32'd0);
        return bp;
    endfunction

    // grow the heap top, 0 when the heap limit would be passed
    function automatic logic [31:0] grow_top(logic [31:0] req_bytes);
        logic [31:0] words;
        logic [31:0] bytes;
        logic [31:0] bp;
        words = req_bytes >> 2;
        if (words[0])
            words++;
        bytes = words << 2;
        if (bytes == 0 || heap_top > HEAP_BYTES || bytes > HEAP_BYTES - heap_top)
            return 32'd0;
        bp = heap_top;
        heap_top += bytes;
        mark_block(bp, bytes, 32'd0);
        tag_wr(bp + bytes - 4, bta_pkg::ALLOC_BIT);
        return merge_neighbours(bp);
    endfunction

    function automatic logic [31:0] first_fit_scan(logic [31:0] need);
        logic [31:0] bp;
        logic [31:0] h;
        int          steps;
        bp    = 32'd8;
        steps = 0;
        while (bp < heap_top && steps < HEAP_BYTES / 8 + 2)
        begin
            h = tag_rd(bp - 4);
            if ((h & bta_pkg::SIZE_MASK) == 0)
                return 32'd0;
            if (h[0] == 1'b0 && (h & bta_pkg::SIZE_MASK) >= need)
                return bp;
            bp += h & bta_pkg::SIZE_MASK;
            steps++;
        end
        return 32'd0;
    endfunction

    function automatic void place_fit(logic [31:0] bp, logic [31:0] need);
        logic [31:0] have;
        have = tag_rd(bp - 4) & bta_pkg::SIZE_MASK;
        if (have >= need && have - need >= bta_pkg::MIN_BLOCK)
        begin
            mark_block(bp, need, bta_pkg::ALLOC_BIT);
            mark_block(bp + need, have - need, 32'd0);
        end
        else
            mark_block(bp, have, bta_pkg::ALLOC_BIT);
    endfunction

    // expected reply for one accepted item, also tracks the live payload offsets
    function automatic reply_t predict_reply(bta_pkg::code_t act, logic [15:0] req,
                                             logic [15:0] addr);
        reply_t      r;
        logic [31:0] need;
        logic [31:0] bp;
        logic [31:0] h;
        r = '{bta_pkg::ST_OK, 16'd0};
        case (act)
            bta_pkg::ACT_INIT:
            begin
                heap_top = 32'd16;
                tag_wr(0, 32'd0);
                tag_wr(4, bta_pkg::PRO_TAG);
                tag_wr(8, bta_pkg::PRO_TAG);
                tag_wr(12, bta_pkg::ALLOC_BIT);
                live_blocks.delete();
                heap_built = (grow_top(32'(CHUNK_BYTES)) != 0);
                if (!heap_built)
                    r.st = bta_pkg::ST_NO_SPACE;
            end
            bta_pkg::ACT_ALLOC:
            begin
                if (!heap_built)
                    r.st = bta_pkg::ST_NOT_READY;
                else if (req == 0)
                    r.st = bta_pkg::ST_NO_SPACE;
                else
                begin
                    need = (req <= 8) ? bta_pkg::MIN_BLOCK :
                        ((32'(req) + 32'd15) & bta_pkg::SIZE_MASK);
                    bp = first_fit_scan(need);
                    if (bp == 0)
                        bp = grow_top(need > 32'(CHUNK_BYTES) ? need : 32'(CHUNK_BYTES));
                    if (bp == 0)
                        r.st = bta_pkg::ST_NO_SPACE;
                    else
                    begin
                        place_fit(bp, need);
                        r.pay = bp[15:0];
                        live_blocks.push_back(bp[15:0]);
                    end
                end
            end
            bta_pkg::ACT_FREE:
            begin
                if (!heap_built)
                    r.st = bta_pkg::ST_NOT_READY;
                else if (addr >= 16 && addr[2:0] == 3'd0 && 32'(addr) < heap_top)
                begin
                    h = tag_rd(32'(addr) - 32'd4);
                    if ((h & bta_pkg::SIZE_MASK) != 0 && h[0])
                    begin
                        mark_block(32'(addr), h & bta_pkg::SIZE_MASK, 32'd0);
                        void'(merge_neighbours(32'(addr)));
                    end
                    foreach (live_blocks[i])
                        if (live_blocks[i] == addr)
                        begin
                            live_blocks.delete(i);
                            break;
                        end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offer one item and wait until it is taken
    task automatic send_item(bta_pkg::code_t act, logic [15:0] req, logic [15:0] addr,
                             logic typed, reply_t typed_reply);
        reply_t r;
        while ((pace == PACE_SENDER && $urandom_range(99) < 81) ||
               (pace == PACE_BOTH && $urandom_range(99) < 9))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {6'd0, addr, req, act};
        s_axis_tvalid <= 1'b1;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        r = predict_reply(act, req, addr);
        pending_replies.push_back(typed ? typed_reply : r);
        items_sent++;
    endtask

    // random item: mostly allocate and free of live blocks, some noise
    task automatic send_random();
        int          pick;
        int          sel;
        logic [15:0] req;
        logic [15:0] addr;
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        req  = 16'($urandom);
        addr = 16'($urandom);
        if (pick < 2)
            send_item(bta_pkg::ACT_INIT, req, addr, 1'b0, '0);
        else if (pick < 47)
        begin
            if (sel < 70)
                req = 16'($urandom_range(64, 1));
            else if (sel < 90)
                req = 16'($urandom_range(1024, 65));
            else if (sel < 97)
                req = 16'($urandom_range(8192, 1025));
            send_item(bta_pkg::ACT_ALLOC, req, addr, 1'b0, '0);
        end
        else if (pick < 92 && live_blocks.size() > 0)
            send_item(bta_pkg::ACT_FREE, req,
                      live_blocks[$urandom_range(live_blocks.size() - 1)], 1'b0, '0);
        else if (pick < 95)
            send_item(ACT_NONE, req, addr, 1'b0, '0);
        else
        begin
            // misplaced free: low, unaligned or beyond the heap top
            if (sel < 33)
                addr = 16'($urandom_range(15));
            else if (sel < 66)
                addr[2:0] = 3'($urandom_range(7, 1));
            else
                addr = 16'($urandom_range(65535, heap_top > 65535 ? 65535 : heap_top));
            send_item(bta_pkg::ACT_FREE, req, addr, 1'b0, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("tb_boundary_tag_first_fit_allocator failed");
        $finish;
    end

    // receiver readiness, with one long hold-off so that the block backs up
    initial
    begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= 60)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (2000)
                    @(posedge clk);
            end
            if (pace == PACE_RECEIVER)
                m_axis_tready <= ($urandom_range(99) >= 81);
            else if (pace == PACE_BOTH)
                m_axis_tready <= ($urandom_range(99) >= 9);
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checking, sampled on the falling edge ahead of the taking edge
    always @(negedge clk)
    begin
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tdata[1:0] !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[17:2] !== want.pay)
                begin
                    $display("%0t: payload_address expected %0d actual %0d",
                             $time, want.pay, m_axis_tdata[17:2]);
                    fail_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int waited;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        fail_count    = 0;
        items_sent    = 0;
        pace          = PACE_FULL;
        heap_top      = 32'd0;
        heap_built    = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].req, dir_rows[i].addr,
                      dir_rows[i].typed, '{dir_rows[i].st, dir_rows[i].pay});
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pace = pace_t'(n / 132 > 3 ? 3 : n / 132);
            if (n % 132 > 110)
                pace = PACE_FULL;
            send_random();
        end
        s_axis_tvalid <= 1'b0;
        pace = PACE_FULL;
        waited = 0;
        while (pending_replies.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100)
            @(posedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("tb_boundary_tag_first_fit_allocator passed");
        else
            $display("tb_boundary_tag_first_fit_allocator failed");
        $finish;
    end
endmodule
